[design/ssa_pkg.sv]
`default_nettype none
package ssa_pkg;

   // Pool geometry
   localparam int POOL_SLOTS   = 64;
   localparam int MAX_SEGMENTS = 16;
   localparam int CHUNK_SIZE   = 8;
   localparam int NUM_CHUNKS   = POOL_SLOTS / CHUNK_SIZE;
   localparam int LANE_W       = $clog2(CHUNK_SIZE);
   localparam int CHUNK_W      = $clog2(NUM_CHUNKS);

   // Field widths
   localparam int CMD_W      = 2;
   localparam int OFFSET_W   = 48;
   localparam int SLOT_W     = 6;
   localparam int SEG_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int NSEG_W     = 5;
   localparam int SPS_W      = 7;
   localparam int PSS_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   // Request word layout
   localparam int REQ_SLOT_LSB = OFFSET_W;
   localparam int REQ_SEG_LSB  = OFFSET_W + SLOT_W;

   // Response word layout
   localparam int RSP_COUNT_LSB = SLOT_W;
   localparam int RSP_FREE_BIT  = SLOT_W + COUNT_W;
   localparam int RSP_EMPTY_BIT = SLOT_W + COUNT_W + 1;

   // Preferred segment: offset >> (page shift + extra), modulo segments
   localparam int SEG_OFFSET_EXTRA_SHIFT = 6;
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = OFFSET_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD      = 3'd6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SEGMENTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_PER_SEG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT    = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic bound;
      logic scan;
      logic pick;
      logic release_slot;
      logic flags;
      logic emit;
   } ssa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             cfg_ok;
      logic             seg_ok;
      logic             div_last;
      logic             out_free;
   } ssa_stat_type;

   // Lowest set bit of an 8-bit group
   function automatic logic [LANE_W-1:0] first_set(input logic [CHUNK_SIZE-1:0] v);
      logic [LANE_W-1:0] pos;
      pos = '0;
      for (int i = CHUNK_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = LANE_W'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

[design/segmented_slot_allocator.sv]
// Slot allocator over a 64-slot pool split into equal segments. A reserve word
// picks a preferred segment from the file offset, (offset >> (page shift + 6))
// mod segments, and grants the first free slot at or after that segment's first
// slot, wrapping around the active pool; a release word frees one slot and a
// query word reports whether a segment has any slot reserved. Every result
// carries the reserved count and the free-slot and empty flags. One word is in
// work at a time: a reserve goes through the modulo unit, which folds eight offset
// bits per cycle, and then, like a query, through the bound, scan, pick and flag
// stages; a release goes through the release and flag stages, and a word with a
// bad command or configuration straight to the flag stage. The next word is
// accepted in the cycle after the result is loaded into the output register.
// Reserved bits are flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none
module segmented_slot_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_we,
   input  wire logic [ssa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssa_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [ssa_pkg::CMD_W-1:0]      req_tuser,  // cmd
   input  wire logic [ssa_pkg::REQ_DATA_W-1:0] req_tdata,  // file_offset, slot_index,
                                                           // segment_index, zero pad
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [ssa_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   output logic [ssa_pkg::RSP_DATA_W-1:0]      rsp_tdata   // granted_slot, reserved_count,
                                                           // has_free, is_empty, zero pad
);
   import ssa_pkg::*;

   ssa_cmd_type  ctl;
   ssa_stat_type stat;

   ssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   ssa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .stat       (stat)
   );

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !(rsp_tvalid && !rsp_tready))
      else $error("result loaded over a waiting word");

   // A grant leaves at least one slot reserved
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_GRANTED)) |-> !rsp_tdata[RSP_EMPTY_BIT])
      else $error("grant reported with empty pool");

   // A full answer means no free slot in the active pool
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_FULL)) |-> !rsp_tdata[RSP_FREE_BIT])
      else $error("full reported while a slot is free");

endmodule
`default_nettype wire

[design/ssa_ctrl.sv]
`default_nettype none
module ssa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire ssa_pkg::ssa_stat_type stat,
   output ssa_pkg::ssa_cmd_type      ctl
);
   import ssa_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_BOUND  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_PICK   = 4'd5;
   localparam logic [3:0] S_REL    = 4'd6;
   localparam logic [3:0] S_FLAGS  = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Sequence one word through the datapath
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.cfg_ok) begin
               state_in = S_FLAGS;
            end else begin
               case (stat.cmd)
                  CMD_RESERVE: state_in = S_DIV;
                  CMD_RELEASE: state_in = S_REL;
                  CMD_QUERY:   state_in = stat.seg_ok ? S_BOUND : S_FLAGS;
                  default:     state_in = S_FLAGS;
               endcase
            end
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            ctl.bound = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            ctl.pick = 1'b1;
            state_in = S_FLAGS;
         end
         S_REL: begin
            ctl.release_slot = 1'b1;
            state_in         = S_FLAGS;
         end
         S_FLAGS: begin
            ctl.flags = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (stat.out_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[design/ssa_datapath.sv]
`default_nettype none
module ssa_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ssa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ssa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [ssa_pkg::CMD_W-1:0]         req_tuser,
   input  wire logic [ssa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ssa_pkg::STATUS_W-1:0]           rsp_tuser,
   output logic [ssa_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire ssa_pkg::ssa_cmd_type              ctl,
   output ssa_pkg::ssa_stat_type                  stat
);
   import ssa_pkg::*;

   // Configuration registers
   logic [NSEG_W-1:0] num_seg_ff;
   logic [SPS_W-1:0]  sps_ff;
   logic [PSS_W-1:0]  pss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_seg_ff <= NSEG_W'(1);
         sps_ff     <= SPS_W'(64);
         pss_ff     <= PSS_W'(14);
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_SEGMENTS:  num_seg_ff <= csr_wdata[NSEG_W-1:0];
            CSR_SLOTS_PER_SEG: sps_ff     <= csr_wdata[SPS_W-1:0];
            CSR_PAGE_SHIFT:    pss_ff     <= csr_wdata[PSS_W-1:0];
            default: ;
         endcase
      end
   end

   // Active pool size, zero when the configuration is unusable
   logic [NSEG_W+SPS_W-1:0] pool_prod;
   logic                    cfg_ok;
   logic [COUNT_W-1:0]      active_n;

   assign pool_prod = {{SPS_W{1'b0}}, num_seg_ff} * {{NSEG_W{1'b0}}, sps_ff};
   assign cfg_ok    = (num_seg_ff != '0) && (num_seg_ff <= NSEG_W'(MAX_SEGMENTS))
                   && (sps_ff != '0) && (pool_prod <= (NSEG_W+SPS_W)'(POOL_SLOTS));
   assign active_n  = cfg_ok ? pool_prod[COUNT_W-1:0] : '0;

   // Item registers
   logic [CMD_W-1:0]     cmd_ff;
   logic [SLOT_W-1:0]    sidx_ff;
   logic [SEG_W-1:0]     seg_ff;
   logic [OFFSET_W-1:0]  quot_ff;
   logic [OFFSET_W-1:0]  quot_in;
   logic [SEG_W-1:0]     rem_ff;
   logic [SEG_W-1:0]     rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PSS_W:0]       shift_amt;

   assign shift_amt = {1'b0, pss_ff} + (PSS_W+1)'(SEG_OFFSET_EXTRA_SHIFT);

   // Modulo unit: fold eight quotient bits into the remainder per step
   always_comb begin
      logic [SEG_W:0] r;
      r = {1'b0, rem_ff};
      for (int j = 0; j < DIV_BITS; j++) begin
         r = {r[SEG_W-1:0], quot_ff[OFFSET_W-1-j]};
         if (r >= num_seg_ff) begin
            r = r - num_seg_ff;
         end
      end
      rem_in  = r[SEG_W-1:0];
      quot_in = quot_ff << DIV_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff     <= req_tuser;
         sidx_ff    <= req_tdata[REQ_SLOT_LSB +: SLOT_W];
         seg_ff     <= req_tdata[REQ_SEG_LSB +: SEG_W];
         quot_ff    <= req_tdata[OFFSET_W-1:0] >> shift_amt;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (ctl.div_step) begin
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Search window bounds: [lo, hi) first, then [0, lo)
   logic [SEG_W+SPS_W-1:0] base_prod;
   logic [COUNT_W:0]       seg_end;
   logic [COUNT_W-1:0]     lo_ff;
   logic [COUNT_W-1:0]     hi_ff;

   assign base_prod = {{SPS_W{1'b0}}, (cmd_ff == CMD_QUERY) ? seg_ff : rem_ff}
                    * {{SEG_W{1'b0}}, sps_ff};
   assign seg_end   = {1'b0, base_prod[COUNT_W-1:0]} + {1'b0, sps_ff};

   always_ff @(posedge clock) begin
      if (ctl.bound) begin
         lo_ff <= base_prod[COUNT_W-1:0];
         hi_ff <= (cmd_ff == CMD_QUERY) ? seg_end[COUNT_W-1:0] : active_n;
      end
   end

   // Slot state
   logic [POOL_SLOTS-1:0] reserved_ff;
   logic [POOL_SLOTS-1:0] reserved_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [SLOT_W-1:0]     granted_ff;
   logic [SLOT_W-1:0]     granted_in;

   // Scan stage: mask the target bits by window, reduce per chunk
   logic [POOL_SLOTS-1:0] target;
   logic [POOL_SLOTS-1:0] vec_a;
   logic [POOL_SLOTS-1:0] vec_b;
   logic [NUM_CHUNKS-1:0] hit_a;
   logic [NUM_CHUNKS-1:0] hit_b;
   logic [NUM_CHUNKS-1:0] free_chunk;
   logic [POOL_SLOTS-1:0] vec_a_ff;
   logic [POOL_SLOTS-1:0] vec_b_ff;
   logic [NUM_CHUNKS-1:0] hit_a_ff;
   logic [NUM_CHUNKS-1:0] hit_b_ff;
   logic [NUM_CHUNKS-1:0] free_chunk_ff;

   assign target = (cmd_ff == CMD_QUERY) ? reserved_ff : ~reserved_ff;

   always_comb begin
      logic [POOL_SLOTS-1:0] in_pool;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         vec_a[i]   = target[i] && (COUNT_W'(i) >= lo_ff) && (COUNT_W'(i) < hi_ff);
         vec_b[i]   = target[i] && (COUNT_W'(i) < lo_ff);
         in_pool[i] = !reserved_ff[i] && (COUNT_W'(i) < active_n);
      end
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         hit_a[c]      = |vec_a[c*CHUNK_SIZE +: CHUNK_SIZE];
         hit_b[c]      = |vec_b[c*CHUNK_SIZE +: CHUNK_SIZE];
         free_chunk[c] = |in_pool[c*CHUNK_SIZE +: CHUNK_SIZE];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan) begin
         vec_a_ff <= vec_a;
         vec_b_ff <= vec_b;
         hit_a_ff <= hit_a;
         hit_b_ff <= hit_b;
      end
      if (ctl.flags) begin
         free_chunk_ff <= free_chunk;
      end
   end

   // Pick stage: first chunk with a hit, then first slot inside it
   logic                  use_a;
   logic                  found;
   logic [CHUNK_W-1:0]    sel_chunk;
   logic [CHUNK_SIZE-1:0] sel_bits;
   logic [SLOT_W-1:0]     pick_idx;

   assign use_a     = |hit_a_ff;
   assign found     = use_a || (|hit_b_ff);
   assign sel_chunk = use_a ? first_set(hit_a_ff) : first_set(hit_b_ff);
   assign sel_bits  = use_a ? vec_a_ff[sel_chunk*CHUNK_SIZE +: CHUNK_SIZE]
                            : vec_b_ff[sel_chunk*CHUNK_SIZE +: CHUNK_SIZE];
   assign pick_idx  = {sel_chunk, first_set(sel_bits)};

   // Update slot state and result
   always_comb begin
      reserved_in = reserved_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      if (ctl.load) begin
         status_in  = ST_BAD;
         granted_in = '0;
      end else if (ctl.pick) begin
         if (cmd_ff == CMD_QUERY) begin
            status_in = use_a ? ST_BUSY : ST_IDLE;
         end else if (found) begin
            reserved_in[pick_idx] = 1'b1;
            count_in              = count_ff + COUNT_W'(1);
            granted_in            = pick_idx;
            status_in             = ST_GRANTED;
         end else begin
            status_in = ST_FULL;
         end
      end else if (ctl.release_slot) begin
         if ({1'b0, sidx_ff} < active_n) begin
            if (reserved_ff[sidx_ff]) begin
               reserved_in[sidx_ff] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               status_in = ST_RELEASED;
            end else begin
               status_in = ST_ALREADY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         count_ff    <= '0;
      end else begin
         reserved_ff <= reserved_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   // Output register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_user_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {1'b0, (count_ff == '0), (|free_chunk_ff), count_ff, granted_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status back to the controller
   assign stat.cmd      = cmd_ff;
   assign stat.cfg_ok   = cfg_ok;
   assign stat.seg_ok   = ({1'b0, seg_ff} < num_seg_ff);
   assign stat.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire
